// File: src/odc_pkg.sv
package odc_pkg;

    // Field widths
    localparam int ActW     = 2;
    localparam int CountW   = 16;
    localparam int ByteW    = 8;
    localparam int DistW    = 11;
    localparam int TimeW    = 16;
    localparam int LampW    = 4;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;

    // Event codes
    localparam logic [ActW-1:0] ACT_TICK    = 2'd0;
    localparam logic [ActW-1:0] ACT_MEASURE = 2'd1;
    localparam logic [ActW-1:0] ACT_BYTE    = 2'd2;

    // Frame bytes and replies
    localparam logic [ByteW-1:0] BYTE_HEAD  = 8'hAA;
    localparam logic [ByteW-1:0] BYTE_TAIL  = 8'h55;
    localparam logic [ByteW-1:0] TX_TRIGGER = 8'hA1;
    localparam logic [ByteW-1:0] TX_ACK     = 8'hCC;
    localparam logic [ByteW-1:0] TX_DONE    = 8'hDD;
    localparam logic [ByteW-1:0] TX_ERROR   = 8'hEE;
    localparam logic [ByteW-1:0] TX_NONE    = 8'h00;
    localparam logic [ByteW-1:0] CLASS_MIN  = 8'h01;
    localparam logic [ByteW-1:0] CLASS_MAX  = 8'h04;

    // Distance conversion: count / 54 == (count >> 1) / 27, done by reciprocal
    localparam logic [DistW-1:0] DIST_NO_ECHO = 11'd999;
    localparam logic [15:0]      DIV_RECIP    = 16'd38837;
    localparam int               DIV_SHIFT    = 20;

    // Register indexes
    localparam logic [CfgIdxW-1:0] CFG_THRESHOLD = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_HEAD_TO   = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_BYTE_TO   = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_SHOW      = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_HOLDOFF   = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_BLINK     = 3'd5;

    // Register reset values
    localparam logic [DistW-1:0] RST_THRESHOLD = 11'd15;
    localparam logic [TimeW-1:0] RST_HEAD_TO   = 16'd30000;
    localparam logic [TimeW-1:0] RST_BYTE_TO   = 16'd1000;
    localparam logic [TimeW-1:0] RST_SHOW      = 16'd1500;
    localparam logic [TimeW-1:0] RST_HOLDOFF   = 16'd2550;
    localparam logic [TimeW-1:0] RST_BLINK     = 16'd350;

endpackage

// File: src/odc_ifs.sv
interface odc_item_if
    import odc_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [ActW-1:0]   action;
    logic [CountW-1:0] echo_count;
    logic              echo_timeout;
    logic [ByteW-1:0]  rx_byte;

    modport source (output valid, action, echo_count, echo_timeout, rx_byte, input ready);
    modport sink   (input valid, action, echo_count, echo_timeout, rx_byte, output ready);
endinterface

interface odc_res_if
    import odc_pkg::*;
    ();
    logic             valid;
    logic             ready;
    logic             tx_valid;
    logic [ByteW-1:0] tx_byte;
    logic [LampW-1:0] class_leds;
    logic             detect_led;
    logic             measure_request;
    logic [DistW-1:0] distance_cm;

    modport source (output valid, tx_valid, tx_byte, class_leds, detect_led,
                    measure_request, distance_cm, input ready);
    modport sink   (input valid, tx_valid, tx_byte, class_leds, detect_led,
                    measure_request, distance_cm, output ready);
endinterface

interface odc_cfg_if
    import odc_pkg::*;
    ();
    logic                valid;
    logic                ready;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: src/odc_dist.sv
module odc_dist
    import odc_pkg::*;
(
    input  logic [CountW-1:0] echo_count,
    input  logic              echo_timeout,
    output logic [DistW-1:0]  distance_cm
);

    logic [CountW-2:0] half;
    logic [30:0]       prod;

    // Halve, then multiply by the reciprocal of 27; exact over the full count range
    assign half = echo_count[CountW-1:1];
    assign prod = 31'(half) * 31'(DIV_RECIP);

    assign distance_cm = echo_timeout ? DIST_NO_ECHO : prod[DIV_SHIFT +: DistW];

endmodule

// File: src/object_detect_classify_handshake.sv
// Path: an item is held in the input register, then registered into the result register.
// Throughput: one item per cycle unless a result stalls; phase and timer update in a single pass.
// Stalls: the input register takes a new item when empty or when its held item advances.
// Reset: rst_n asynchronous, active low; phase returns to measure, lamps off, timer,
// class code and distance cleared, registers back to their default values.
module object_detect_classify_handshake
    import odc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    odc_item_if.sink   meas,
    odc_res_if.source  result,
    odc_cfg_if.sink    cfg
);

    typedef enum logic [2:0] {
        PH_MEASURE,
        PH_HEAD,
        PH_CLASS,
        PH_TAIL,
        PH_SHOW,
        PH_HOLD,
        PH_BLINK
    } phase_t;

    // Configuration registers
    logic [DistW-1:0] threshold_reg;
    logic [TimeW-1:0] head_to_reg;
    logic [TimeW-1:0] byte_to_reg;
    logic [TimeW-1:0] show_reg;
    logic [TimeW-1:0] holdoff_reg;
    logic [TimeW-1:0] blink_reg;

    // Input register
    logic              in_valid_reg;
    logic [ActW-1:0]   action_reg;
    logic [CountW-1:0] echo_count_reg;
    logic              echo_timeout_reg;
    logic [ByteW-1:0]  rx_byte_reg;

    // Controller state
    phase_t           phase_reg, phase_next;
    logic [TimeW-1:0] timer_reg, timer_next;
    logic [ByteW-1:0] class_code_reg, class_code_next;
    logic             lamp_detect_reg, lamp_detect_next;
    logic [LampW-1:0] lamp_class_reg, lamp_class_next;
    logic [DistW-1:0] dist_reg, dist_next;

    // Result register
    logic             out_valid_reg;
    logic             tx_valid_reg;
    logic [ByteW-1:0] tx_byte_reg;

    logic             advance;
    logic             send;
    logic [ByteW-1:0] tx;
    logic [TimeW-1:0] timer_inc;
    logic [TimeW-1:0] limit;
    logic [TimeW-1:0] limit_eff;
    logic             expired;
    logic [DistW-1:0] meas_dist;
    logic [1:0]       class_idx;
    logic             class_ok;

    // Configuration writes are always taken
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= RST_THRESHOLD;
            head_to_reg   <= RST_HEAD_TO;
            byte_to_reg   <= RST_BYTE_TO;
            show_reg      <= RST_SHOW;
            holdoff_reg   <= RST_HOLDOFF;
            blink_reg     <= RST_BLINK;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_THRESHOLD: threshold_reg <= cfg.data[DistW-1:0];
                CFG_HEAD_TO:   head_to_reg   <= cfg.data;
                CFG_BYTE_TO:   byte_to_reg   <= cfg.data;
                CFG_SHOW:      show_reg      <= cfg.data;
                CFG_HOLDOFF:   holdoff_reg   <= cfg.data;
                CFG_BLINK:     blink_reg     <= cfg.data;
                default:       ;
            endcase
        end
    end

    // Advance the held item when the result register is free or being drained
    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign meas.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (meas.ready)
            in_valid_reg <= meas.valid;
    end

    // Hold the input payload on each transfer
    always_ff @(posedge clk)
    begin
        if (meas.valid && meas.ready)
        begin
            action_reg       <= meas.action;
            echo_count_reg   <= meas.echo_count;
            echo_timeout_reg <= meas.echo_timeout;
            rx_byte_reg      <= meas.rx_byte;
        end
    end

    odc_dist u_dist (
        .echo_count   (echo_count_reg),
        .echo_timeout (echo_timeout_reg),
        .distance_cm  (meas_dist)
    );

    // Pick the time limit of the current wait; a zero limit acts as one
    always_comb
    begin
        unique case (phase_reg) inside
            PH_HEAD:           limit = head_to_reg;
            PH_CLASS, PH_TAIL: limit = byte_to_reg;
            PH_SHOW:           limit = show_reg;
            PH_HOLD:           limit = holdoff_reg;
            PH_BLINK:          limit = blink_reg;
            default:           limit = '0;
        endcase
    end

    assign limit_eff = (limit == '0) ? TimeW'(1) : limit;
    assign timer_inc = timer_reg + TimeW'(1);
    assign expired   = (timer_inc >= limit_eff);
    assign class_idx = 2'(class_code_reg - CLASS_MIN);
    assign class_ok  = (class_code_reg >= CLASS_MIN) && (class_code_reg <= CLASS_MAX);

    // Next state and reply byte for the held event
    always_comb
    begin
        phase_next       = phase_reg;
        timer_next       = timer_reg;
        class_code_next  = class_code_reg;
        lamp_detect_next = lamp_detect_reg;
        lamp_class_next  = lamp_class_reg;
        dist_next        = dist_reg;
        send             = 1'b0;
        tx               = TX_NONE;

        case (action_reg)
            ACT_TICK:
            begin
                unique case (phase_reg) inside
                    PH_HEAD, PH_CLASS, PH_TAIL:
                    begin
                        timer_next = timer_inc;
                        if (expired)
                        begin
                            lamp_detect_next = 1'b0;
                            phase_next       = PH_HOLD;
                            timer_next       = '0;
                            send             = 1'b1;
                            tx               = TX_ERROR;
                        end
                    end
                    PH_SHOW:
                    begin
                        timer_next = timer_inc;
                        if (expired)
                        begin
                            lamp_class_next  = '0;
                            lamp_detect_next = 1'b0;
                            phase_next       = PH_HOLD;
                            timer_next       = '0;
                            send             = 1'b1;
                            tx               = TX_DONE;
                        end
                    end
                    PH_HOLD, PH_BLINK:
                    begin
                        timer_next = timer_inc;
                        if (expired)
                        begin
                            phase_next = PH_MEASURE;
                            timer_next = '0;
                        end
                    end
                    default: ;
                endcase
            end
            ACT_MEASURE:
            begin
                if (phase_reg == PH_MEASURE)
                begin
                    dist_next  = meas_dist;
                    timer_next = '0;
                    if (meas_dist <= threshold_reg)
                    begin
                        lamp_detect_next = 1'b1;
                        phase_next       = PH_HEAD;
                        send             = 1'b1;
                        tx               = TX_TRIGGER;
                    end
                    else
                    begin
                        lamp_detect_next = !lamp_detect_reg;
                        phase_next       = PH_BLINK;
                    end
                end
            end
            ACT_BYTE:
            begin
                unique case (phase_reg) inside
                    PH_HEAD:
                    begin
                        timer_next = '0;
                        if (rx_byte_reg == BYTE_HEAD)
                            phase_next = PH_CLASS;
                        else
                        begin
                            lamp_detect_next = 1'b0;
                            phase_next       = PH_HOLD;
                            send             = 1'b1;
                            tx               = TX_ERROR;
                        end
                    end
                    PH_CLASS:
                    begin
                        class_code_next = rx_byte_reg;
                        phase_next      = PH_TAIL;
                        timer_next      = '0;
                    end
                    PH_TAIL:
                    begin
                        timer_next = '0;
                        send       = 1'b1;
                        if ((rx_byte_reg == BYTE_TAIL) && class_ok)
                        begin
                            lamp_class_next = LampW'(1) << class_idx;
                            phase_next      = PH_SHOW;
                            tx              = TX_ACK;
                        end
                        else
                        begin
                            lamp_detect_next = 1'b0;
                            phase_next       = PH_HOLD;
                            tx               = TX_ERROR;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // Hold controller state and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_MEASURE;
            timer_reg       <= '0;
            class_code_reg  <= '0;
            lamp_detect_reg <= 1'b0;
            lamp_class_reg  <= '0;
            dist_reg        <= '0;
            out_valid_reg   <= 1'b0;
            tx_valid_reg    <= 1'b0;
            tx_byte_reg     <= TX_NONE;
        end
        else
        begin
            if (advance)
            begin
                phase_reg       <= phase_next;
                timer_reg       <= timer_next;
                class_code_reg  <= class_code_next;
                lamp_detect_reg <= lamp_detect_next;
                lamp_class_reg  <= lamp_class_next;
                dist_reg        <= dist_next;
                out_valid_reg   <= 1'b1;
                tx_valid_reg    <= send;
                tx_byte_reg     <= tx;
            end
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // The result shows the state left by the item that produced it
    assign result.valid           = out_valid_reg;
    assign result.tx_valid        = tx_valid_reg;
    assign result.tx_byte         = tx_byte_reg;
    assign result.class_leds      = lamp_class_reg;
    assign result.detect_led      = lamp_detect_reg;
    assign result.measure_request = (phase_reg == PH_MEASURE);
    assign result.distance_cm     = dist_reg;

endmodule

// File: src/odc_check.sv
module odc_check
    import odc_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_ready,
    input logic             tx_valid,
    input logic [ByteW-1:0] tx_byte,
    input logic [LampW-1:0] class_leds,
    input logic             detect_led
);

    // A stalled result holds until it is taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(class_leds))
        else $error("result changed while stalled");

    // No byte code without a transfer request
    a_tx_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !tx_valid |-> tx_byte == TX_NONE)
        else $error("tx_byte set without tx_valid");

    // Only the four reply codes are ever sent
    a_tx_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tx_valid |->
            (tx_byte == TX_TRIGGER) || (tx_byte == TX_ACK) ||
            (tx_byte == TX_DONE) || (tx_byte == TX_ERROR))
        else $error("unknown reply code");

    // At most one class lamp, and only while the detect lamp is lit
    a_class_lamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0(class_leds) && (class_leds == '0 || detect_led))
        else $error("class lamp state inconsistent");

    // An acknowledge always comes with a class lamp lit
    a_ack_lamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tx_valid && tx_byte == TX_ACK |-> class_leds != '0)
        else $error("acknowledge without class lamp");

endmodule

bind object_detect_classify_handshake odc_check u_odc_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .tx_valid   (result.tx_valid),
    .tx_byte    (result.tx_byte),
    .class_leds (result.class_leds),
    .detect_led (result.detect_led)
);
